/* rtl/bium_pkg.sv */
// ----------------------------------------------------------------------------
// bium_pkg: shared types and constants for the usable memory summer
// Field widths, tag and status codes, and the queue word between the
// front and back ends.
// ----------------------------------------------------------------------------
package bium_pkg;

  localparam int WORD_W   = 32;
  localparam int SUM_W    = 64;
  localparam int STATUS_W = 2;
  localparam int LANES    = WORD_W / 8;

  // Tag types and layout
  localparam logic [WORD_W-1:0] TAG_END     = 32'd0;
  localparam logic [WORD_W-1:0] TAG_MMAP    = 32'd6;
  localparam logic [WORD_W-1:0] MIN_SIZE    = 32'd8;
  localparam logic [WORD_W-1:0] MIN_FIRST   = 32'd16;
  localparam logic [WORD_W-1:0] MIN_STRIDE  = 32'd20;
  localparam logic [WORD_W-1:0] MAP_HDR     = 32'd16;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_END_TAG     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SMALL_TOTAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SMALL_TAG   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 2'd3;

  // Queue between front and back end
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // One queued word. For a setup word, word carries the entry size and
  // offset carries the tag length.
  typedef struct packed {
    logic                clr;
    logic                setup;
    logic                ent;
    logic                fin;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   offset;
    logic [WORD_W-1:0]   size;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/bium_if.sv */
// ----------------------------------------------------------------------------
// bium_if: stream channels of the usable memory summer
// Input word channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bium_in_if;
  import bium_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              start_req;

  modport source (output valid, word, start_req, input ready);
  modport sink   (input valid, word, start_req, output ready);
endinterface

interface bium_out_if;
  import bium_pkg::*;

  logic                valid;
  logic                ready;
  logic [SUM_W-1:0]    sum_bytes;
  logic [WORD_W-1:0]   usable_mib;
  logic [WORD_W-1:0]   block_size;
  logic [STATUS_W-1:0] status;

  modport source (output valid, sum_bytes, usable_mib, block_size, status,
                  input ready);
  modport sink   (input valid, sum_bytes, usable_mib, block_size, status,
                  output ready);
endinterface

/* rtl/bium_front.sv */
// ----------------------------------------------------------------------------
// bium_front: tag walker
// Tracks the block header and tag boundaries, decides when the parse ends
// and queues the words that the entry walker needs.
// ----------------------------------------------------------------------------
module bium_front (
  input  logic             clk,
  input  logic             rst_n,
  bium_in_if.sink          in_chan,
  input  bium_pkg::q_stat_t q_stat,
  output bium_pkg::pkt_t   pkt,
  output logic             pkt_valid
);
  import bium_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_RSVD = 4'b0010,
    PH_TAG  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [WORD_W-1:0] off_r, off_nxt;
  logic [WORD_W-1:0] size_r, size_nxt;
  logic [WORD_W-1:0] tag_begin_r, tag_begin_nxt;
  logic [WORD_W-1:0] tlen_r, tlen_nxt;
  logic              is_map_r, is_map_nxt;
  logic              stride_ok_r, stride_ok_nxt;
  logic [WORD_W:0]   padded_r, padded_nxt;
  logic              over_r, over_nxt;
  logic [WORD_W-1:0] next_r, next_nxt;

  logic              accept;
  logic [WORD_W-1:0] w;
  logic              end_now;
  logic              over;
  logic [WORD_W-1:0] next_tag;

  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign w             = in_chan.word;

  always_comb begin
    phase_nxt     = phase_r;
    off_nxt       = off_r;
    size_nxt      = size_r;
    tag_begin_nxt = tag_begin_r;
    tlen_nxt      = tlen_r;
    is_map_nxt    = is_map_r;
    stride_ok_nxt = stride_ok_r;
    padded_nxt    = padded_r;
    over_nxt      = over_r;
    next_nxt      = next_r;
    end_now       = 1'b0;
    over          = over_r;
    next_tag      = next_r;
    pkt           = '0;
    pkt.word      = w;
    pkt.offset    = off_r;
    pkt.size      = size_r;
    pkt_valid     = 1'b0;

    if (accept) begin
      if (in_chan.start_req) begin
        // restart: clear the sum behind us
        size_nxt   = w;
        off_nxt    = '0;
        is_map_nxt = 1'b0;
        pkt.clr    = 1'b1;
        pkt.size   = w;
        pkt_valid  = 1'b1;
        if (w < MIN_SIZE) begin
          pkt.fin    = 1'b1;
          pkt.status = ST_SMALL_TOTAL;
          phase_nxt  = PH_DONE;
        end else if (w < MIN_FIRST) begin
          pkt.fin    = 1'b1;
          pkt.status = ST_EXHAUSTED;
          phase_nxt  = PH_DONE;
        end else begin
          phase_nxt = PH_RSVD;
        end
      end else begin
        unique case (phase_r)
          PH_RSVD: begin
            tag_begin_nxt = MIN_SIZE;
            off_nxt       = '0;
            phase_nxt     = PH_TAG;
          end
          PH_TAG: begin
            if (off_r == '0) begin
              if (w == TAG_END) begin
                pkt.fin    = 1'b1;
                pkt.status = ST_END_TAG;
                pkt_valid  = 1'b1;
                phase_nxt  = PH_DONE;
              end else begin
                is_map_nxt = (w == TAG_MMAP);
                off_nxt    = 32'd4;
              end
            end else if (off_r == 32'd4 && w < MIN_SIZE) begin
              pkt.fin    = 1'b1;
              pkt.status = ST_SMALL_TAG;
              pkt_valid  = 1'b1;
              phase_nxt  = PH_DONE;
            end else begin
              if (off_r == 32'd4) begin
                // size word: an 8-byte tag ends right here
                tlen_nxt   = w;
                padded_nxt = ({1'b0, w} + 33'd7) & ~33'd7;
                end_now    = (w == MIN_SIZE);
                over       = ({2'b0, tag_begin_r} + 34'd16) > {2'b0, size_r};
                next_tag   = tag_begin_r + MIN_SIZE;
              end else if (off_r == 32'd8) begin
                // entry size word; precompute where this tag lands
                stride_ok_nxt = (w >= MIN_STRIDE);
                over_nxt      = ({2'b0, tag_begin_r} + {1'b0, padded_r} + 34'd8)
                                > {2'b0, size_r};
                next_nxt      = tag_begin_r + padded_r[WORD_W-1:0];
                if (is_map_r) begin
                  pkt.setup  = 1'b1;
                  pkt.offset = tlen_r;
                  pkt_valid  = 1'b1;
                end
              end else begin
                end_now = ({1'b0, off_r} + 33'd4) >= padded_r;
                if (off_r >= MAP_HDR && is_map_r && stride_ok_r) begin
                  pkt.ent   = 1'b1;
                  pkt_valid = 1'b1;
                end
              end
              if (end_now) begin
                if (over) begin
                  pkt.fin    = 1'b1;
                  pkt.status = ST_EXHAUSTED;
                  pkt_valid  = 1'b1;
                  phase_nxt  = PH_DONE;
                end else begin
                  tag_begin_nxt = next_tag;
                  off_nxt       = '0;
                  is_map_nxt    = 1'b0;
                end
              end else begin
                off_nxt = off_r + 32'd4;
              end
            end
          end
          PH_IDLE, PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r       <= off_nxt;
    size_r      <= size_nxt;
    tag_begin_r <= tag_begin_nxt;
    tlen_r      <= tlen_nxt;
    is_map_r    <= is_map_nxt;
    stride_ok_r <= stride_ok_nxt;
    padded_r    <= padded_nxt;
    over_r      <= over_nxt;
    next_r      <= next_nxt;
  end

endmodule

/* rtl/bium_fifo.sv */
// ----------------------------------------------------------------------------
// bium_fifo: front-to-back queue
// Small first-in first-out buffer of queued words.
// ----------------------------------------------------------------------------
module bium_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  bium_pkg::pkt_t    push_pkt,
  input  logic              pop,
  output bium_pkg::pkt_t    head,
  output bium_pkg::q_stat_t stat
);
  import bium_pkg::*;

  pkt_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push_valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

endmodule

/* rtl/bium_back.sv */
// ----------------------------------------------------------------------------
// bium_back: entry walker and result register
// Gathers entry bytes across word lanes, adds usable lengths and holds
// the result until taken.
// ----------------------------------------------------------------------------
module bium_back (
  input  logic           clk,
  input  logic           rst_n,
  input  bium_pkg::pkt_t head,
  input  logic           head_valid,
  output logic           pop,
  bium_out_if.source     out_chan
);
  import bium_pkg::*;

  logic [WORD_W-1:0]   eb_r, eb_nxt;
  logic [WORD_W-1:0]   stride_r, stride_nxt;
  logic [WORD_W-1:0]   tlen_r, tlen_nxt;
  logic [SUM_W-1:0]    held_r, held_nxt;
  logic                type_r, type_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]    bytes_r, bytes_nxt;
  logic [WORD_W-1:0]   size_r, size_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic                fits;
  logic [WORD_W+1:0]   diff;
  logic [WORD_W+1:0]   lane_d [LANES];
  logic [WORD_W:0]     stride_m1;

  assign pop = head_valid && (!head.fin || !out_valid_r || out_chan.ready);

  assign fits      = ({1'b0, eb_r} + {1'b0, stride_r}) <= {1'b0, tlen_r};
  assign diff      = {2'b0, head.offset} - {2'b0, eb_r};
  assign stride_m1 = {1'b0, stride_r} - 33'd1;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_d[i] = diff + (WORD_W + 2)'(i);
    end
  end

  always_comb begin
    logic [WORD_W:0] dv;
    logic [7:0]      v;
    logic            t;
    logic            add_en;
    logic            adv;

    eb_nxt        = eb_r;
    stride_nxt    = stride_r;
    tlen_nxt      = tlen_r;
    held_nxt      = held_r;
    type_nxt      = type_r;
    sum_nxt       = sum_r;
    bytes_nxt     = bytes_r;
    size_nxt      = size_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    t             = type_r;
    add_en        = 1'b0;
    adv           = 1'b0;
    dv            = '0;
    v             = '0;

    if (pop) begin
      if (head.clr) begin
        sum_nxt = '0;
      end
      if (head.setup) begin
        eb_nxt     = MAP_HDR;
        stride_nxt = head.word;
        tlen_nxt   = head.offset;
      end
      if (head.ent && fits) begin
        // walk the byte lanes in address order; at most one entry ends here
        for (int i = 0; i < LANES; i++) begin
          dv = lane_d[i][WORD_W:0];
          v  = head.word[8*i +: 8];
          if (!lane_d[i][WORD_W+1]) begin
            if (dv[WORD_W:3] == 30'd1) begin
              held_nxt[8*dv[2:0] +: 8] = v;
            end else if (dv == 33'd16) begin
              t = (v == 8'd1);
            end else if (dv >= 33'd17 && dv <= 33'd19) begin
              t = t && (v == 8'd0);
              if (dv == 33'd19 && t) begin
                add_en = 1'b1;
              end
            end
            if (dv == stride_m1) begin
              adv = 1'b1;
            end
          end
        end
        type_nxt = t;
        if (add_en) begin
          sum_nxt = sum_r + held_r;
        end
        if (adv) begin
          eb_nxt = eb_r + stride_r;
        end
      end
      if (head.fin) begin
        out_valid_nxt = 1'b1;
        bytes_nxt     = sum_nxt;
        size_nxt      = head.size;
        status_nxt    = head.status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eb_r     <= eb_nxt;
    stride_r <= stride_nxt;
    tlen_r   <= tlen_nxt;
    held_r   <= held_nxt;
    type_r   <= type_nxt;
    bytes_r  <= bytes_nxt;
    size_r   <= size_nxt;
    status_r <= status_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sum_bytes  = bytes_r;
  assign out_chan.usable_mib = bytes_r[WORD_W+19:20];
  assign out_chan.block_size = size_r;
  assign out_chan.status     = status_r;

endmodule

/* rtl/boot_info_usable_memory_sum.sv */
// ----------------------------------------------------------------------------
// boot_info_usable_memory_sum: usable memory summer for a boot info block
// Walks the tags of a boot information block word by word and sums the
// lengths of usable memory map entries.
// ----------------------------------------------------------------------------
//
//   channel   direction  carries                                   word
//   in_chan   sink       word[31:0], start_req                     one per cycle unless queue full
//   out_chan  source     sum_bytes, usable_mib, block_size,        one per parse
//                        status
//
// One input word per cycle while the queue has room. The front end walks
// the tag headers and queues only the words that matter to the back end;
// the back end takes one queued word per cycle unless a finishing word waits
// on a full result register, so both halves keep up with one word per cycle.
// The finishing word is registered in the queue, then in the result register.
// Reset is synchronous and active low; it idles the parser and empties the
// four-word queue. When the result register is full and not taken, only a
// finishing word stalls; in_chan.ready drops once the queue fills.
// ----------------------------------------------------------------------------
module boot_info_usable_memory_sum (
  input  logic        clk,
  input  logic        rst_n,
  bium_in_if.sink     in_chan,
  bium_out_if.source  out_chan
);
  import bium_pkg::*;

  pkt_t    q_push_pkt;
  logic    q_push;
  pkt_t    q_head;
  q_stat_t q_stat;
  logic    back_pop;

  // Front end: classify words, decide the end of a parse
  bium_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_stat    (q_stat),
    .pkt       (q_push_pkt),
    .pkt_valid (q_push)
  );

  // Decouple the two halves so each can stall on its own
  bium_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_pkt   (q_push_pkt),
    .pop        (back_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  // Back end: gather entries, add usable lengths, hold the result
  bium_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_stat.empty),
    .pop        (back_pop),
    .out_chan   (out_chan)
  );

`ifndef NO_ASSERTIONS
  // The front end never queues a word into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue overflow");

  // A new result only follows a finishing word taken by the back end
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(back_pop && q_head.fin))
    else $error("result without finishing word");

  // A total size below the minimum reports an empty sum
  a_small_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == ST_SMALL_TOTAL)
      |-> (out_chan.sum_bytes == '0))
    else $error("nonzero sum for undersized block");
`endif

endmodule

/* sim/tb_boot_info_usable_memory_sum.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_boot_info_usable_memory_sum: stream test of the usable memory summer
// Builds boot information blocks byte by byte, streams them word by word with
// random gaps and stalls, tracks the walk in a local tag walker and checks
// every result word against the oldest expected report.
// ----------------------------------------------------------------------------
module tb_boot_info_usable_memory_sum;
  import bium_pkg::*;

  localparam int          STALL_LIMIT  = 2000;  // cycles with no word moving
  localparam int          DRAIN_CYCLES = 20;
  localparam int          ITEM_TARGET  = 1550;  // input words to send
  localparam logic [31:0] RAM_USABLE   = 32'd1;
  localparam int          ENT_LEN_AT   = 8;     // entry layout, in bytes
  localparam int          ENT_TYPE_AT  = 16;
  localparam int          ENT_HDR      = 20;

  typedef enum logic [3:0] {
    WALK_IDLE = 4'b0001,
    WALK_RSVD = 4'b0010,
    WALK_TAG  = 4'b0100,
    WALK_DONE = 4'b1000
  } walk_phase_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum_bytes;
    logic [WORD_W-1:0]   usable_mib;
    logic [WORD_W-1:0]   block_size;
    logic [STATUS_W-1:0] status;
  } sum_report_t;

  logic clk;
  logic rst_n;

  bium_in_if  in_chan ();
  bium_out_if out_chan ();

  boot_info_usable_memory_sum dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Tag walker state, mirrors what the block tracks per word
  walk_phase_t       walk_phase;
  logic [31:0]       tag_off;       // byte offset of the word inside the tag
  logic [31:0]       blk_size;
  logic [31:0]       tag_base;      // block offset of the current tag
  logic [31:0]       tag_len;
  logic              in_map;
  logic [31:0]       stride;
  logic [31:0]       ent_base;      // tag-relative offset of the current entry
  logic [63:0]       ent_len;
  logic [63:0]       usable_sum;
  logic              ent_usable;

  sum_report_t       pending_reports[$];
  logic [7:0]        blk_bytes[$];
  int unsigned       words_sent;
  int unsigned       mismatches;
  int unsigned       idle_cycles;
  bit                src_idle;
  bit                snk_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Tag walker
  // --------------------------------------------------------------------------
  function automatic void clear_walk();
    walk_phase = WALK_IDLE;
    tag_off    = '0;
    blk_size   = '0;
    tag_base   = '0;
    tag_len    = '0;
    in_map     = 1'b0;
    stride     = '0;
    ent_base   = '0;
    ent_len    = '0;
    usable_sum = '0;
    ent_usable = 1'b0;
  endfunction

  function automatic bit close_block(output sum_report_t rep,
                                     input logic [STATUS_W-1:0] st);
    rep.sum_bytes  = usable_sum;
    rep.usable_mib = usable_sum[51:20];
    rep.block_size = blk_size;
    rep.status     = st;
    walk_phase     = WALK_DONE;
    return 1'b1;
  endfunction

  // Gather the four byte lanes of a map word into the current entry.
  function automatic void gather_entry_bytes(input logic [31:0] w, input logic [31:0] r);
    int          i;
    logic [63:0] b;
    logic [63:0] d;
    logic [7:0]  v;
    for (i = 0; i < LANES; i++) begin
      b = 64'(r) + 64'(i);
      v = w[8*i +: 8];
      // stop once the entry would spill past the tag
      if (64'(ent_base) + 64'(stride) > 64'(tag_len)) return;
      if (b < 64'(ent_base)) continue;
      d = b - 64'(ent_base);
      if (d >= ENT_LEN_AT && d < ENT_TYPE_AT) begin
        if (d == ENT_LEN_AT) ent_len = 64'(v);
        else ent_len |= 64'(v) << (8 * (d - ENT_LEN_AT));
      end else if (d == ENT_TYPE_AT) begin
        ent_usable = (v == RAM_USABLE[7:0]);
      end else if (d > ENT_TYPE_AT && d < ENT_HDR) begin
        ent_usable = ent_usable && (v == 8'd0);
        if (d == ENT_HDR - 1 && ent_usable) usable_sum += ent_len;
      end
      if (d == 64'(stride) - 64'd1) ent_base += stride;
    end
  endfunction

  // Advance the walk by one word; return 1 with the report when the parse ends.
  function automatic bit walk_word(input logic [31:0] w, input logic s,
                                   output sum_report_t rep);
    logic [31:0] r;
    logic [63:0] padded;
    logic [63:0] next_base;
    rep = '0;
    if (s) begin
      clear_walk();
      blk_size = w;
      if (w < MIN_SIZE) return close_block(rep, ST_SMALL_TOTAL);
      if (w < MIN_FIRST) return close_block(rep, ST_EXHAUSTED);
      walk_phase = WALK_RSVD;
      return 1'b0;
    end
    if (walk_phase == WALK_RSVD) begin
      tag_base   = MIN_SIZE;
      tag_off    = '0;
      walk_phase = WALK_TAG;
      return 1'b0;
    end
    if (walk_phase != WALK_TAG) return 1'b0;

    r = tag_off;
    if (r == 0) begin
      if (w == TAG_END) return close_block(rep, ST_END_TAG);
      in_map  = (w == TAG_MMAP);
      tag_off = 32'd4;
      return 1'b0;
    end
    if (r == 4) begin
      if (w < MIN_SIZE) return close_block(rep, ST_SMALL_TAG);
      tag_len = w;
    end else if (r == 8) begin
      stride   = w;
      ent_base = MAP_HDR;
    end else if (r >= MAP_HDR && in_map && stride >= MIN_STRIDE) begin
      gather_entry_bytes(w, r);
    end

    // pad the tag length in 64 bits so a size near 2^32 cannot wrap
    padded = (64'(tag_len) + 64'd7) & ~64'd7;
    if (64'(r) + 64'd4 >= padded) begin
      next_base = 64'(tag_base) + padded;
      if (next_base + 64'd8 > 64'(blk_size)) return close_block(rep, ST_EXHAUSTED);
      tag_base = next_base[31:0];
      tag_off  = '0;
      in_map   = 1'b0;
      return 1'b0;
    end
    tag_off = r + 32'd4;
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Block builder: bytes in stream order, packed little-endian into words
  // --------------------------------------------------------------------------
  function automatic void put_bytes(input logic [63:0] v, input int n);
    int k;
    for (k = 0; k < n; k++) blk_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void put_rand(input int n);
    int k;
    for (k = 0; k < n; k++) blk_bytes.push_back(8'($urandom));
  endfunction

  function automatic void set_total(input logic [31:0] v);
    int k;
    for (k = 0; k < 4; k++) blk_bytes[k] = v[8*k +: 8];
  endfunction

  // Trim or fill the tag body to its declared size, then pad to 8 bytes.
  function automatic void fit_tag(input int base, input logic [31:0] declared);
    int target;
    target = base + ((declared < MIN_SIZE) ? 8 : int'(declared));
    while (blk_bytes.size() > target) void'(blk_bytes.pop_back());
    while (blk_bytes.size() < target || blk_bytes.size() % 8 != 0)
      blk_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_map_tag();
    int          base;
    int          n;
    int          lay;
    int          full;
    int          k;
    logic [31:0] stride_f;
    logic [31:0] declared;
    logic [63:0] len;
    logic [31:0] ty;
    base = blk_bytes.size();
    n    = $urandom_range(0, 4);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: stride_f = 32'd24;
      6:                stride_f = MIN_STRIDE;
      7, 8:             stride_f = $urandom_range(21, 40);
      default:          stride_f = $urandom_range(0, 19);
    endcase
    lay  = (stride_f < MIN_STRIDE) ? 24 : int'(stride_f);
    full = 16 + n * lay;
    case ($urandom_range(0, 9))
      8:       declared = full - $urandom_range(1, lay);
      9:       declared = full + $urandom_range(1, 12);
      default: declared = full;
    endcase
    put_bytes(64'(TAG_MMAP), 4);
    put_bytes(64'(declared), 4);
    put_bytes(64'(stride_f), 4);
    put_rand(4);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0:       len = {$urandom, $urandom};
        1:       len = 64'($urandom);
        2:       len = '1;
        default: len = 64'($urandom_range(1, 4096)) << 20;
      endcase
      case ($urandom_range(0, 9))
        6, 7:    ty = $urandom_range(2, 5);
        8:       ty = RAM_USABLE | (32'($urandom_range(1, 255)) << (8 * $urandom_range(1, 3)));
        9:       ty = $urandom;
        default: ty = RAM_USABLE;
      endcase
      put_bytes({$urandom, $urandom}, 8);
      put_bytes(len, 8);
      put_bytes(64'(ty), 4);
      put_rand(lay - ENT_HDR);
    end
    fit_tag(base, declared);
  endfunction

  // Add a tag other than a map; return 1 when its size runs past the stream.
  function automatic bit add_other_tag();
    int          base;
    int          len;
    int          pick;
    logic [31:0] ty;
    base = blk_bytes.size();
    ty   = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 21);
    if (ty == TAG_END || ty == TAG_MMAP) ty = 32'd7;
    len  = $urandom_range(0, 16);
    pick = $urandom_range(0, 99);
    put_bytes(64'(ty), 4);
    if (pick < 4) begin
      // size field below the minimum ends the parse
      put_bytes(64'($urandom_range(0, 7)), 4);
      put_rand(len);
      fit_tag(base, 32'd8);
    end else if (pick < 7) begin
      // oversized tag: the walk never ends within this block
      put_bytes(64'($urandom_range(32'h8000_0000, 32'hFFFF_FFFF)), 4);
      put_rand($urandom_range(0, 24));
      return 1'b1;
    end else begin
      put_bytes(64'(8 + len), 4);
      put_rand(len);
      fit_tag(base, 32'(8 + len));
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers and checker
  // --------------------------------------------------------------------------
  // Send one word; called at a falling edge, returns at a falling edge.
  task automatic send_word(input logic [31:0] w, input logic s);
    int          gap;
    sum_report_t rep;
    gap = src_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.word      <= w;
    in_chan.start_req <= s;
    do @(posedge clk); while (!in_chan.ready);
    words_sent++;
    if (walk_word(w, s, rep)) pending_reports.push_back(rep);
    @(negedge clk);
  endtask

  // Stream the first n_words words of the built block (all when negative).
  task automatic send_blk(input int n_words);
    int          total;
    int          cnt;
    int          k;
    logic [31:0] w;
    while (blk_bytes.size() % 4 != 0) blk_bytes.push_back(8'($urandom));
    total = blk_bytes.size() / 4;
    cnt   = (n_words < 0 || n_words > total) ? total : n_words;
    for (k = 0; k < cnt; k++) begin
      w = {blk_bytes[4*k+3], blk_bytes[4*k+2], blk_bytes[4*k+1], blk_bytes[4*k]};
      send_word(w, k == 0);
    end
  endtask

  // Result sink: hold ready low for a random stall before each result word.
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = snk_idle ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_chan.valid));
      @(negedge clk);
    end
  end

  task automatic flag_mismatch(input string what, input sum_report_t want,
                               input sum_report_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch (%s): expected %h %h %h %0d, got %h %h %h %0d",
               $realtime, what, want.sum_bytes, want.usable_mib, want.block_size,
               want.status, got.sum_bytes, got.usable_mib, got.block_size, got.status);
  endtask

  // Compare each result word with the oldest pending report.
  always @(posedge clk) begin
    sum_report_t got;
    sum_report_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.sum_bytes  = out_chan.sum_bytes;
      got.usable_mib = out_chan.usable_mib;
      got.block_size = out_chan.block_size;
      got.status     = out_chan.status;
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.sum_bytes !== want.sum_bytes || got.usable_mib !== want.usable_mib ||
            got.block_size !== want.block_size || got.status !== want.status)
          flag_mismatch("field", want, got);
      end
    end
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Total sizes below 8 report at once; 8 to 15 leave no room for a tag.
  task automatic test_short_totals();
    send_word(32'd0, 1'b1);
    send_word(32'd7, 1'b1);
    send_word(32'd8, 1'b1);
    send_word(32'd15, 1'b1);
    send_word($urandom, 1'b0);  // finished: dropped without a result
  endtask

  // End tag right after the header; the size word behind it is dropped.
  task automatic test_end_tag();
    blk_bytes.delete();
    put_bytes(64'd16, 4);
    put_bytes(64'd0, 4);
    put_bytes(64'(TAG_END), 4);
    put_bytes(64'd8, 4);
    send_blk(-1);
  endtask

  task automatic test_short_tag();
    blk_bytes.delete();
    put_bytes(64'd32, 4);
    put_rand(4);
    put_bytes(64'd1, 4);
    put_bytes(64'd7, 4);
    send_blk(-1);
  endtask

  // Map tag with a 21-byte entry: bytes straddle words, the tag pads from
  // 37 to 40 bytes and runs past a total size of 32.
  task automatic test_unaligned_overrun();
    blk_bytes.delete();
    put_bytes(64'd32, 4);
    put_rand(4);
    put_bytes(64'(TAG_MMAP), 4);
    put_bytes(64'd37, 4);
    put_bytes(64'd21, 4);
    put_rand(4);
    put_bytes({$urandom, $urandom}, 8);
    put_bytes(64'h0000_0001_2340_0000, 8);
    put_bytes(64'(RAM_USABLE), 4);
    put_rand(1);
    fit_tag(8, 32'd37);
    send_blk(-1);
  endtask

  // Entry size below 20: the usable entry inside must not count.
  task automatic test_small_stride();
    blk_bytes.delete();
    put_bytes(64'd48, 4);
    put_rand(4);
    put_bytes(64'(TAG_MMAP), 4);
    put_bytes(64'd36, 4);
    put_bytes(64'd19, 4);
    put_rand(4);
    put_bytes({$urandom, $urandom}, 8);
    put_bytes('1, 8);
    put_bytes(64'(RAM_USABLE), 4);
    fit_tag(8, 32'd36);
    send_blk(-1);
  endtask

  // Tag size near 2^32: walk a few words, then abandon it with a new start.
  task automatic test_oversized_tag();
    blk_bytes.delete();
    put_bytes(64'd64, 4);
    put_rand(4);
    put_bytes(64'd5, 4);
    put_bytes(64'h0000_0000_FFFF_FFFC, 4);
    put_rand(12);
    send_blk(-1);
  endtask

  // Mostly well-formed blocks with random content, some cut short, some noise.
  task automatic test_random_blocks();
    int          kind;
    int          ntags;
    int          t;
    int          len;
    int          k;
    bit          cut;
    logic [31:0] tot;
    while (words_sent < ITEM_TARGET) begin
      // pick idling per block, leaving some stretches with none at all
      case ($urandom_range(0, 3))
        0:       begin src_idle = 1'b1; snk_idle = 1'b1; end
        1:       begin src_idle = 1'b1; snk_idle = 1'b0; end
        2:       begin src_idle = 1'b0; snk_idle = 1'b1; end
        default: begin src_idle = 1'b0; snk_idle = 1'b0; end
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        send_word(32'($urandom_range(0, 15)), 1'b1);
      end else if (kind < 12) begin
        for (k = 0; k < $urandom_range(1, 6); k++)
          send_word($urandom, $urandom_range(0, 7) == 0);
      end else begin
        blk_bytes.delete();
        put_bytes(64'd0, 4);
        put_rand(4);
        ntags = $urandom_range(0, 3);
        cut   = 1'b0;
        for (t = 0; t < ntags && !cut; t++) begin
          if ($urandom_range(0, 9) < 6) add_map_tag();
          else cut = add_other_tag();
        end
        if (!cut && $urandom_range(0, 9) < 8) begin
          put_bytes(64'(TAG_END), 4);
          put_bytes(64'd8, 4);
        end
        len = blk_bytes.size();
        case ($urandom_range(0, 9))
          7:       tot = $urandom_range(0, len);
          8:       tot = len + $urandom_range(1, 64);
          9:       tot = $urandom;
          default: tot = len;
        endcase
        set_total(tot);
        // cut some blocks short so the next start breaks in mid-walk
        send_blk(($urandom_range(0, 9) == 0) ? $urandom_range(1, len / 4) : -1);
        for (k = 0; k < $urandom_range(0, 2); k++) send_word($urandom, 1'b0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.word      = '0;
    in_chan.start_req = 1'b0;
    words_sent        = 0;
    mismatches        = 0;
    idle_cycles       = 0;
    src_idle          = 1'b1;
    snk_idle          = 1'b1;
    clear_walk();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_short_totals();
    test_end_tag();
    test_short_tag();
    test_unaligned_overrun();
    test_small_stride();
    test_oversized_tag();
    test_random_blocks();

    // drop valid, wait for every pending report, then let the pipe settle
    in_chan.valid <= 1'b0;
    wait (pending_reports.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bium_pkg.sv
rtl/bium_if.sv
rtl/bium_front.sv
rtl/bium_fifo.sv
rtl/bium_back.sv
rtl/boot_info_usable_memory_sum.sv
sim/tb_boot_info_usable_memory_sum.sv
